// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TPIP_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// next-cycle implication
`define TPIP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define TPIP_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define TPIP_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ----- src/tpip_pkg.sv -----
// ---------------------------------------------------------------------------
// tpip_pkg
// Types and constants of the transformed point-in-polygon block.
// ---------------------------------------------------------------------------
package tpip_pkg;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TEST = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_VERTEX_COUNT = 3'd0,
      REG_SCALE_X      = 3'd1,
      REG_SCALE_Y      = 3'd2,
      REG_COS_ANGLE    = 3'd3,
      REG_SIN_ANGLE    = 3'd4,
      REG_OFFSET_X     = 3'd5,
      REG_OFFSET_Y     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // classified item as it waits between front and back
   typedef struct packed {
      logic               is_test;
      logic               in_range;
      logic [5:0]         vertex_index;
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } entry_type;

   typedef struct packed {
      logic [6:0]         vertex_count;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
   } cfg_type;

endpackage

// ----- src/tpip_if.sv -----
// ---------------------------------------------------------------------------
// tpip_if
// Valid/ready channels of the block: request, response and register write.
// ---------------------------------------------------------------------------
interface tpip_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [5:0]         vertex_index;
   logic signed [15:0] vertex_x;
   logic signed [15:0] vertex_y;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   modport source (output valid, command, vertex_index, vertex_x, vertex_y,
                   point_x, point_y, input ready);
   modport sink (input valid, command, vertex_index, vertex_x, vertex_y,
                 point_x, point_y, output ready);
endinterface

interface tpip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

interface tpip_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tpip_ram.sv -----
// ---------------------------------------------------------------------------
// tpip_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tpip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/tpip_front.sv -----
// ---------------------------------------------------------------------------
// tpip_front
// Accepts request items and classifies them into load or test entries.
// ---------------------------------------------------------------------------
module tpip_front #(
   parameter int MAX_VERTICES = 64
) (
   tpip_req_if.sink             req,
   input  logic                 q_ready,
   output logic                 q_push,
   output tpip_pkg::entry_type  q_entry
);

   // accept whenever the queue has room
   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;

   // classify: command and table slot range
   always_comb begin
      q_entry              = '0;
      q_entry.is_test      = (tpip_pkg::cmd_type'(req.command) == tpip_pkg::CMD_TEST);
      q_entry.in_range     = (32'(req.vertex_index) < 32'(MAX_VERTICES));
      q_entry.vertex_index = req.vertex_index;
      q_entry.vertex_x     = req.vertex_x;
      q_entry.vertex_y     = req.vertex_y;
      q_entry.point_x      = req.point_x;
      q_entry.point_y      = req.point_y;
   end

endmodule

// ----- src/tpip_queue.sv -----
// ---------------------------------------------------------------------------
// tpip_queue
// Short queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module tpip_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tpip_pkg::entry_type  push_entry,
   output logic                 in_ready,
   input  logic                 pop,
   output logic                 out_valid,
   output tpip_pkg::entry_type  head
);

   localparam int PW = $clog2(tpip_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(tpip_pkg::QUEUE_DEPTH + 1);

   tpip_pkg::entry_type slot_ff [tpip_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign in_ready  = (count_ff != CW'(tpip_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tpip_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tpip_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- src/tpip_back.sv -----
// ---------------------------------------------------------------------------
// tpip_back
// Executes loads into the vertex table and walks the edges for a test.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tpip_back #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tpip_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  tpip_pkg::entry_type  q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_inside
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);

   tpip_pkg::state_type state_ff, state_in;

   logic [CW-1:0] n;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] addr_full;
   logic          few;
   logic          ram_we, issue, start, emit_short, emit_run;
   logic [AW-1:0] raddr;
   logic [31:0]   rdata;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_inside_ff, rsp_inside_in;
   logic inside_ff, inside_in;
   logic signed [31:0] px_ff, py_ff;

   // active vertex count, saturated to the table size
   always_comb begin
      if (32'(cfg.vertex_count) > 32'(MAX_VERTICES)) begin
         n = CW'(MAX_VERTICES);
      end else begin
         n = CW'(cfg.vertex_count);
      end
   end
   assign few = (n < CW'(3));

   // read order: last vertex, then 0 .. n-1
   assign addr_full = (cnt_ff == '0) ? n - 1'b1 : cnt_ff - 1'b1;
   assign raddr     = addr_full[AW-1:0];

   tpip_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(q_entry.vertex_index)),
      .wdata ({q_entry.vertex_x, q_entry.vertex_y}),
      .raddr (raddr),
      .rdata (rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpip_pkg::ST_IDLE: begin
            if (q_valid && q_entry.is_test && !few && !rsp_valid_ff) begin
               state_in = tpip_pkg::ST_RUN;
            end
         end
         tpip_pkg::ST_RUN: begin
            if (cnt_ff == n) begin
               state_in = tpip_pkg::ST_DRAIN;
            end
         end
         tpip_pkg::ST_DRAIN: begin
            if (emit_run) begin
               state_in = tpip_pkg::ST_IDLE;
            end
         end
         default: state_in = tpip_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_pop      = 1'b0;
      ram_we     = 1'b0;
      start      = 1'b0;
      emit_short = 1'b0;
      issue      = 1'b0;
      unique case (state_ff)
         tpip_pkg::ST_IDLE: begin
            if (q_valid && !q_entry.is_test) begin
               q_pop  = 1'b1;
               ram_we = q_entry.in_range;
            end else if (q_valid && !rsp_valid_ff) begin
               q_pop      = 1'b1;
               emit_short = few;
               start      = !few;
            end
         end
         tpip_pkg::ST_RUN:   issue = 1'b1;
         tpip_pkg::ST_DRAIN: issue = 1'b0;
         default:            issue = 1'b0;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // ---------------- transform and edge pipeline ----------------
   logic rd_v_ff, rd_first_ff, rd_last_ff;
   logic s2_v_ff, s2_first_ff, s2_last_ff;
   logic s3_v_ff, s3_first_ff, s3_last_ff;
   logic s4_v_ff, s4_first_ff, s4_last_ff;
   logic s5_v_ff, s5_last_ff;
   logic s6_v_ff, s6_last_ff;
   logic s7_v_ff, s7_last_ff;

   logic signed [15:0] vx, vy;
   logic signed [47:0] mx, my;
   logic signed [33:0] sx_ff, sy_ff;
   logic signed [49:0] csx_ff, ssy_ff, ssx_ff, csy_ff;
   logic signed [50:0] rx, ry;
   logic signed [37:0] wx_ff, wy_ff, pwx_ff, pwy_ff;
   logic signed [37:0] px_w, py_w;
   logic signed [38:0] a_ff, b_ff, c_ff, d_ff;
   logic               cross_ff, dypos_ff;
   logic               cross5_ff, dypos5_ff, cross6_ff, dypos6_ff;
   logic signed [59:0] ab_lo_ff, cd_lo_ff;
   logic signed [57:0] ab_hi_ff, cd_hi_ff;
   logic signed [77:0] ab_ff, cd_ff;
   logic               lt, hit;

   assign vx = rdata[31:16];
   assign vy = rdata[15:0];
   assign mx = vx * cfg.scale_x;
   assign my = vy * cfg.scale_y;
   assign rx = 51'(csx_ff) - 51'(ssy_ff);
   assign ry = 51'(ssx_ff) + 51'(csy_ff);
   assign px_w = 38'(px_ff);
   assign py_w = 38'(py_ff);

   // compare the exact products; direction follows the sign of dy
   assign lt  = dypos6_ff ? (ab_ff < cd_ff) : (cd_ff < ab_ff);
   assign hit = cross6_ff && lt;
   assign emit_run = s7_v_ff && s7_last_ff;

   always_ff @(posedge clock) begin
      // scale
      sx_ff  <= mx[47:14];
      sy_ff  <= my[47:14];
      // rotate
      csx_ff <= cfg.cos_angle * sx_ff;
      ssy_ff <= cfg.sin_angle * sy_ff;
      ssx_ff <= cfg.sin_angle * sx_ff;
      csy_ff <= cfg.cos_angle * sy_ff;
      // offset
      wx_ff  <= 38'($signed(rx[50:14])) + 38'(cfg.offset_x);
      wy_ff  <= 38'($signed(ry[50:14])) + 38'(cfg.offset_y);
      // edge operands against the previous vertex
      if (s4_v_ff) begin
         pwx_ff <= wx_ff;
         pwy_ff <= wy_ff;
      end
      a_ff     <= 39'(px_w) - 39'(wx_ff);
      b_ff     <= 39'(pwy_ff) - 39'(wy_ff);
      c_ff     <= 39'(pwx_ff) - 39'(wx_ff);
      d_ff     <= 39'(py_w) - 39'(wy_ff);
      cross_ff <= !s4_first_ff && ((wy_ff > py_w) != (pwy_ff > py_w));
      dypos_ff <= (pwy_ff > wy_ff);
      // partial products, second operand split at bit 20
      ab_lo_ff  <= a_ff * $signed({1'b0, b_ff[19:0]});
      ab_hi_ff  <= a_ff * $signed(b_ff[38:20]);
      cd_lo_ff  <= c_ff * $signed({1'b0, d_ff[19:0]});
      cd_hi_ff  <= c_ff * $signed(d_ff[38:20]);
      cross5_ff <= cross_ff;
      dypos5_ff <= dypos_ff;
      // combine
      ab_ff     <= (78'(ab_hi_ff) <<< 20) + 78'(ab_lo_ff);
      cd_ff     <= (78'(cd_hi_ff) <<< 20) + 78'(cd_lo_ff);
      cross6_ff <= cross5_ff;
      dypos6_ff <= dypos5_ff;
      if (start) begin
         px_ff <= q_entry.point_x;
         py_ff <= q_entry.point_y;
      end
   end

   // stage valids and tags
   always_ff @(posedge clock) begin
      if (reset) begin
         {rd_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff} <= '0;
      end else begin
         rd_v_ff <= issue;
         s2_v_ff <= rd_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff <= (cnt_ff == '0);
      rd_last_ff  <= (cnt_ff == n);
      s2_first_ff <= rd_first_ff;
      s2_last_ff  <= rd_last_ff;
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s4_first_ff <= s3_first_ff;
      s4_last_ff  <= s3_last_ff;
      s5_last_ff  <= s4_last_ff;
      s6_last_ff  <= s5_last_ff;
      s7_last_ff  <= s6_last_ff;
   end

   // crossing parity and result slot
   always_comb begin
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_inside_in = rsp_inside_ff;
      if (start) begin
         inside_in = 1'b0;
      end else if (s7_v_ff) begin
         inside_in = inside_ff ^ hit;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_short) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = 1'b0;
      end else if (s7_v_ff && s7_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_inside_in = inside_ff ^ hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpip_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff     <= inside_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_inside = rsp_inside_ff;

   // the last edge finds the result slot empty
   `TPIP_ASSERT_IMPLY(a_slot_free, clock, reset, s7_v_ff && s7_last_ff, !rsp_valid_ff)
   // table writes never overlap a walk
   `TPIP_ASSERT_IMPLY(a_write_idle, clock, reset, ram_we, !rd_v_ff && !s6_v_ff)
   // a result follows the end of the walk
   `TPIP_ASSERT_NEXT(a_emit_done, clock, reset, emit_run, state_ff == tpip_pkg::ST_IDLE)

endmodule

// ----- src/transformed_point_in_polygon.sv -----
// ---------------------------------------------------------------------------
// transformed_point_in_polygon
// Even-odd point-in-polygon test against a scaled, rotated, offset polygon.
// ---------------------------------------------------------------------------
//   channel  dir  carries
//   req_ch   in   command, vertex slot and vertex, or test point
//   rsp_ch   out  inside_res, one per test item
//   csr_ch   in   register index and write data, always ready
//
// A load in range writes its table slot as it leaves the queue. A test with
// n vertices walks n + 1 entries through the single read port of the vertex
// table, then the transform and compare pipeline; under three vertices it is
// answered as outside without a walk. Reset is synchronous; the table is not
// cleared. A waiting result holds the next test; the queue takes items until full.
// ---------------------------------------------------------------------------
module transformed_point_in_polygon #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   tpip_req_if.sink    req_ch,
   tpip_rsp_if.source  rsp_ch,
   tpip_csr_if.sink    csr_ch
);

   tpip_pkg::cfg_type   cfg_ff, cfg_in;
   tpip_pkg::entry_type push_entry, head;
   logic push, q_ready, pop, q_valid;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (tpip_pkg::reg_index_type'(csr_ch.index))
            tpip_pkg::REG_VERTEX_COUNT: cfg_in.vertex_count = csr_ch.data[6:0];
            tpip_pkg::REG_SCALE_X:      cfg_in.scale_x      = csr_ch.data;
            tpip_pkg::REG_SCALE_Y:      cfg_in.scale_y      = csr_ch.data;
            tpip_pkg::REG_COS_ANGLE:    cfg_in.cos_angle    = csr_ch.data[15:0];
            tpip_pkg::REG_SIN_ANGLE:    cfg_in.sin_angle    = csr_ch.data[15:0];
            tpip_pkg::REG_OFFSET_X:     cfg_in.offset_x     = csr_ch.data;
            tpip_pkg::REG_OFFSET_Y:     cfg_in.offset_y     = csr_ch.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count <= 7'd0;
         cfg_ff.scale_x      <= 32'sd4096;
         cfg_ff.scale_y      <= 32'sd4096;
         cfg_ff.cos_angle    <= 16'sd16384;
         cfg_ff.sin_angle    <= 16'sd0;
         cfg_ff.offset_x     <= 32'sd0;
         cfg_ff.offset_y     <= 32'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpip_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .req     (req_ch),
      .q_ready (q_ready),
      .q_push  (push),
      .q_entry (push_entry)
   );

   tpip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .in_ready   (q_ready),
      .pop        (pop),
      .out_valid  (q_valid),
      .head       (head)
   );

   tpip_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (head),
      .q_pop      (pop),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_inside (rsp_ch.inside_res)
   );

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the transformed point-in-polygon block. Loads the
// vertex table and writes the registers through their channels, runs directed
// and random test points, and compares each inside flag with a local model.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVERT = 64;
   localparam int WATCH_LIMIT = 20000;
   localparam int LONG_HOLD = 2000;

   typedef struct {
      tpip_pkg::cmd_type  cmd;
      logic [5:0]         slot;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [31:0] px;
      logic signed [31:0] py;
   } poly_item_type;

   logic clock;
   logic reset;

   tpip_req_if req_ch ();
   tpip_rsp_if rsp_ch ();
   tpip_csr_if csr_ch ();

   transformed_point_in_polygon #(.MAX_VERTICES(NVERT)) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // mirror of the block's registers and vertex table
   tpip_pkg::cfg_type  shadow_cfg;
   logic signed [15:0] shadow_x [NVERT];
   logic signed [15:0] shadow_y [NVERT];

   poly_item_type pending_items [$];
   bit         inside_expected [$];
   int         errors;
   bit         no_idle;
   int         send_gap;
   int         recv_stall;
   int         hold_cnt;
   logic       hold_go;
   int         quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // local vertex moved to world space: scale, rotate, offset
   function automatic void vertex_world(input int k, output longint wx, output longint wy);
      longint sx, sy, c, s;
      sx = (longint'(shadow_x[k]) * longint'(shadow_cfg.scale_x)) >>> 14;
      sy = (longint'(shadow_y[k]) * longint'(shadow_cfg.scale_y)) >>> 14;
      c = longint'(shadow_cfg.cos_angle);
      s = longint'(shadow_cfg.sin_angle);
      wx = ((c * sx - s * sy) >>> 14) + longint'(shadow_cfg.offset_x);
      wy = ((s * sx + c * sy) >>> 14) + longint'(shadow_cfg.offset_y);
   endfunction

   function automatic int live_vertices();
      return (int'(shadow_cfg.vertex_count) > NVERT) ? NVERT : int'(shadow_cfg.vertex_count);
   endfunction

   // even-odd crossing test with cross-multiplied compare
   function automatic bit point_inside(input longint px, input longint py);
      int n, i, j;
      bit hit, result;
      longint ix, iy, jx, jy, dy;
      logic signed [127:0] lhs, rhs;
      result = 1'b0;
      n = live_vertices();
      if (n >= 3) begin
         j = n - 1;
         for (i = 0; i < n; i++) begin
            vertex_world(i, ix, iy);
            vertex_world(j, jx, jy);
            if ((iy > py) != (jy > py)) begin
               dy = jy - iy;
               lhs = 128'(signed'(px - ix)) * 128'(signed'(dy));
               rhs = 128'(signed'(jx - ix)) * 128'(signed'(py - iy));
               hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
               if (hit) result = ~result;
            end
            j = i;
         end
      end
      return result;
   endfunction

   // driver: offer pending items, draw a gap after each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.command == tpip_pkg::CMD_LOAD) begin
               shadow_x[req_ch.vertex_index] = req_ch.vertex_x;
               shadow_y[req_ch.vertex_index] = req_ch.vertex_y;
            end else begin
               inside_expected.push_back(point_inside(longint'(req_ch.point_x),
                                                      longint'(req_ch.point_y)));
            end
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               poly_item_type it;
               it = pending_items.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.command <= it.cmd;
               req_ch.vertex_index <= it.slot;
               req_ch.vertex_x <= it.vx;
               req_ch.vertex_y <= it.vy;
               req_ch.point_x <= it.px;
               req_ch.point_y <= it.py;
               send_gap <= no_idle ? 0 : int'($urandom_range(0, 18));
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) hold_cnt <= 0;
      else if (hold_go) hold_cnt <= LONG_HOLD;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
   end

   // monitor: check each result against the oldest expectation, then stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (inside_expected.size() == 0) begin
               $display("%0t: unexpected result inside_res=%0b", $time, rsp_ch.inside_res);
               errors++;
            end else begin
               bit exp_in;
               exp_in = inside_expected.pop_front();
               if (rsp_ch.inside_res !== exp_in) begin
                  $display("%0t: inside_res expected %0b actual %0b",
                           $time, exp_in, rsp_ch.inside_res);
                  errors++;
               end
            end
         end
         if (hold_cnt > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_ch.valid && rsp_ch.ready && !no_idle)
               recv_stall <= int'($urandom_range(0, 18));
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // write one register and update the mirror
   task automatic write_reg(input tpip_pkg::reg_index_type idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         tpip_pkg::REG_VERTEX_COUNT: shadow_cfg.vertex_count = value[6:0];
         tpip_pkg::REG_SCALE_X:      shadow_cfg.scale_x = value;
         tpip_pkg::REG_SCALE_Y:      shadow_cfg.scale_y = value;
         tpip_pkg::REG_COS_ANGLE:    shadow_cfg.cos_angle = value[15:0];
         tpip_pkg::REG_SIN_ANGLE:    shadow_cfg.sin_angle = value[15:0];
         tpip_pkg::REG_OFFSET_X:     shadow_cfg.offset_x = value;
         tpip_pkg::REG_OFFSET_Y:     shadow_cfg.offset_y = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [6:0] cnt, input logic [31:0] scx, input logic [31:0] scy,
                            input logic [15:0] c, input logic [15:0] s,
                            input logic [31:0] ox, input logic [31:0] oy);
      write_reg(tpip_pkg::REG_VERTEX_COUNT, 32'(cnt));
      write_reg(tpip_pkg::REG_SCALE_X, scx);
      write_reg(tpip_pkg::REG_SCALE_Y, scy);
      write_reg(tpip_pkg::REG_COS_ANGLE, 32'(signed'(c)));
      write_reg(tpip_pkg::REG_SIN_ANGLE, 32'(signed'(s)));
      write_reg(tpip_pkg::REG_OFFSET_X, ox);
      write_reg(tpip_pkg::REG_OFFSET_Y, oy);
   endtask

   // hold until every item is in and every result is out, then let it settle
   task automatic drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || inside_expected.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic queue_load(input int slot, input logic [15:0] vx, input logic [15:0] vy);
      poly_item_type it;
      it.cmd = tpip_pkg::CMD_LOAD;
      it.slot = slot[5:0];
      it.vx = vx;
      it.vy = vy;
      it.px = $urandom();
      it.py = $urandom();
      pending_items.push_back(it);
   endtask

   task automatic queue_test(input logic [31:0] px, input logic [31:0] py);
      poly_item_type it;
      it.cmd = tpip_pkg::CMD_TEST;
      it.slot = 6'($urandom());
      it.vx = 16'($urandom());
      it.vy = 16'($urandom());
      it.px = px;
      it.py = py;
      pending_items.push_back(it);
   endtask

   // test point near the polygon: between two vertices with some jitter
   task automatic queue_near_point();
      int n, a, b;
      longint ax, ay, bx, by;
      n = live_vertices();
      if (n < 1) n = 1;
      a = int'($urandom_range(0, n - 1));
      b = int'($urandom_range(0, n - 1));
      vertex_world(a, ax, ay);
      vertex_world(b, bx, by);
      queue_test(32'((ax + bx) / 2 + longint'($urandom_range(0, 400)) - 200),
                 32'((ay + by) / 2 + longint'($urandom_range(0, 400)) - 200));
   endtask

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         default: return 32'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(1, 4096) * 64);
      endcase
   endfunction

   function automatic logic [15:0] pick_trig();
      case ($urandom_range(0, 4))
         0:       return 16'sd16384;
         1:       return -16'sd16384;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 7'($urandom_range(0, 2));
         1:       return 7'd64;
         2:       return 7'($urandom_range(65, 127));
         default: return 7'($urandom_range(3, 12));
      endcase
   endfunction

   // stimulus
   initial begin
      int ph, k;
      errors = 0;
      no_idle = 1'b0;
      hold_go = 1'b0;
      quiet_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.command = tpip_pkg::CMD_LOAD;
      req_ch.vertex_index = '0;
      req_ch.vertex_x = '0;
      req_ch.vertex_y = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = tpip_pkg::REG_VERTEX_COUNT;
      csr_ch.data = '0;
      shadow_cfg.vertex_count = 7'd0;
      shadow_cfg.scale_x = 32'sd4096;
      shadow_cfg.scale_y = 32'sd4096;
      shadow_cfg.cos_angle = 16'sd16384;
      shadow_cfg.sin_angle = 16'sd0;
      shadow_cfg.offset_x = 32'sd0;
      shadow_cfg.offset_y = 32'sd0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every slot so that no unwritten entry is ever read
      queue_load(0, 16'h8000, 16'h8000);
      queue_load(1, 16'h7FFF, 16'h8000);
      queue_load(2, 16'h7FFF, 16'h7FFF);
      queue_load(3, 16'h8000, 16'h7FFF);
      for (k = 4; k < NVERT; k++) queue_load(k, 16'($urandom()), 16'($urandom()));
      drain();

      // directed: too few vertices, square, saturated count, point extremes
      write_reg(tpip_pkg::REG_VERTEX_COUNT, 32'd0);
      queue_test(32'd0, 32'd0);
      drain();
      write_reg(tpip_pkg::REG_VERTEX_COUNT, 32'd2);
      queue_test(32'd0, 32'd0);
      drain();
      write_reg(tpip_pkg::REG_VERTEX_COUNT, 32'd4);
      queue_test(32'd0, 32'd0);
      queue_test(32'd100, 32'hFFFF_FF00);
      queue_test(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_test(32'h8000_0000, 32'h8000_0000);
      queue_test(32'd8191, 32'd0);
      queue_test(32'hFFFF_E000, 32'd0);
      drain();
      write_reg(tpip_pkg::REG_VERTEX_COUNT, 32'd127);
      queue_test(32'd0, 32'd0);
      queue_test(32'h8000_0000, 32'h7FFF_FFFF);
      drain();
      write_all(7'd4, 32'h7FFF_FFFF, 32'h8000_0000, 16'hC000, 16'h4000,
                32'h7FFF_FFFF, 32'h8000_0000);
      queue_near_point();
      queue_near_point();
      queue_test(32'h7FFF_FFFF, 32'h8000_0000);
      drain();
      write_all(7'd3, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hC000,
                32'h8000_0000, 32'h7FFF_FFFF);
      queue_near_point();
      queue_near_point();
      drain();

      // random phases, each under its own register setting
      for (ph = 0; ph < 11; ph++) begin
         write_all(pick_count(), pick_scale(), pick_scale(), pick_trig(), pick_trig(),
                   ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 2000000)) - 1000000,
                   ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 2000000)) - 1000000);
         no_idle = (ph % 4 == 2);
         for (k = 0; k < 98; k++) begin
            case ($urandom_range(0, 9))
               0, 1: queue_load(int'($urandom_range(0, NVERT - 1)), 16'($urandom()),
                                16'($urandom()));
               2:    queue_test($urandom(), $urandom());
               default: queue_near_point();
            endcase
         end
         if (ph == 3) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         drain();
      end

      drain();
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ----- transformed_point_in_polygon.f -----
+incdir+src
src/tpip_pkg.sv
src/tpip_if.sv
src/tpip_ram.sv
src/tpip_front.sv
src/tpip_queue.sv
src/tpip_back.sv
src/transformed_point_in_polygon.sv
dv/tb_top.sv
